// File: src/kdll_pkg.sv
`timescale 1ns / 1ps
// Shared constants for the keyed doubly linked list unit.
// Command and status codes, field widths and the default pool size.
package kdll_pkg;

    localparam int NODES_DEF = 64;

    localparam int CMD_W     = 2;
    localparam int KEY_W     = 32;
    localparam int NAME_W    = 64;
    localparam int STATUS_W  = 2;
    localparam int ENTRIES_W = 7;

    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INS_AFTER = 2'd1;
    localparam logic [CMD_W-1:0] CMD_INS_BEFORE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd3;

    localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

endpackage

// File: src/kdll_store.sv
`timescale 1ns / 1ps
// Node store of the linked list: key, name, next and prev memories.
// One shared registered read address; key and name share one write port, next and prev have one each. Uses kdll_pkg.
module kdll_store #(
    parameter int NODES = kdll_pkg::NODES_DEF,
    parameter int IW    = $clog2(NODES + 1),
    parameter int AW    = $clog2(NODES)
) (
    input  logic                             i_clk,
    input  logic [AW-1:0]                    i_rd_addr,
    output logic signed [kdll_pkg::KEY_W-1:0] o_rd_key,
    output logic [kdll_pkg::NAME_W-1:0]      o_rd_name,
    output logic [IW-1:0]                    o_rd_next,
    output logic [IW-1:0]                    o_rd_prev,
    input  logic                             i_kn_we,
    input  logic [AW-1:0]                    i_kn_addr,
    input  logic signed [kdll_pkg::KEY_W-1:0] i_key_wdata,
    input  logic [kdll_pkg::NAME_W-1:0]      i_name_wdata,
    input  logic                             i_nx_we,
    input  logic [AW-1:0]                    i_nx_addr,
    input  logic [IW-1:0]                    i_nx_wdata,
    input  logic                             i_pv_we,
    input  logic [AW-1:0]                    i_pv_addr,
    input  logic [IW-1:0]                    i_pv_wdata
);

    logic signed [kdll_pkg::KEY_W-1:0] mem_key  [NODES];
    logic [kdll_pkg::NAME_W-1:0]       mem_name [NODES];
    logic [IW-1:0]                     mem_next [NODES];
    logic [IW-1:0]                     mem_prev [NODES];

    always_ff @(posedge i_clk) begin
        if (i_kn_we) begin
            mem_key[i_kn_addr]  <= i_key_wdata;
            mem_name[i_kn_addr] <= i_name_wdata;
        end
        if (i_nx_we) begin
            mem_next[i_nx_addr] <= i_nx_wdata;
        end
        if (i_pv_we) begin
            mem_prev[i_pv_addr] <= i_pv_wdata;
        end
        o_rd_key  <= mem_key[i_rd_addr];
        o_rd_name <= mem_name[i_rd_addr];
        o_rd_next <= mem_next[i_rd_addr];
        o_rd_prev <= mem_prev[i_rd_addr];
    end

endmodule

// File: src/keyed_doubly_linked_list_unit.sv
`timescale 1ns / 1ps
// Top level of the keyed doubly linked list unit. Uses kdll_pkg and kdll_store.
// Control sequencer that walks the list and rewrites the links.
//
// A command is taken when start is high while busy is low, and exactly one result
// comes back on o_status, o_name_out and o_entries for a single cycle, flagged by
// o_done; the receiver cannot stall it, so it must sample on that cycle. Errors that
// need no lookup (list empty, pool full) answer in the cycle after the transfer. A
// lookup walks the list from the head one node per cycle through the node store's
// registered read port until the matching record or the end of the list; a delete
// then unlinks the node and puts it on the free chain, an insert allocates a node
// and links it in. No clearing pass is needed after reset.
module keyed_doubly_linked_list_unit #(
    parameter int NODES = kdll_pkg::NODES_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [kdll_pkg::CMD_W-1:0]           i_cmd,
    input  logic signed [kdll_pkg::KEY_W-1:0]    i_key,
    input  logic signed [kdll_pkg::KEY_W-1:0]    i_ref_key,
    input  logic [kdll_pkg::NAME_W-1:0]          i_name_in,
    output logic                                 o_done,
    output logic [kdll_pkg::STATUS_W-1:0]        o_status,
    output logic [kdll_pkg::NAME_W-1:0]          o_name_out,
    output logic [kdll_pkg::ENTRIES_W-1:0]       o_entries
);

    localparam int IW = $clog2(NODES + 1);
    localparam int AW = $clog2(NODES);
    localparam logic [IW-1:0] NIL = IW'(NODES);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_WALK  = 3'd1;
    localparam logic [2:0] S_ALLOC = 3'd2;
    localparam logic [2:0] S_POP   = 3'd3;
    localparam logic [2:0] S_LINK1 = 3'd4;
    localparam logic [2:0] S_LINK2 = 3'd5;
    localparam logic [2:0] S_DEL1  = 3'd6;
    localparam logic [2:0] S_DEL2  = 3'd7;

    logic [2:0] r_state, n_state;
    logic [kdll_pkg::CMD_W-1:0] r_cmd, n_cmd;
    logic signed [kdll_pkg::KEY_W-1:0] r_tgt, n_tgt;
    logic signed [kdll_pkg::KEY_W-1:0] r_key, n_key;
    logic [kdll_pkg::NAME_W-1:0] r_name_in, n_name_in;
    logic [kdll_pkg::NAME_W-1:0] r_hit, n_hit;
    logic [IW-1:0] r_at, n_at;
    logic [IW-1:0] r_steps, n_steps;
    logic [IW-1:0] r_p, n_p;
    logic [IW-1:0] r_pn, n_pn;
    logic [IW-1:0] r_pp, n_pp;
    logic [IW-1:0] r_n, n_n;
    logic r_empty, n_empty;
    logic [IW-1:0] r_head, n_head;
    logic [IW-1:0] r_tail, n_tail;
    logic [IW-1:0] r_count, n_count;
    logic [IW-1:0] r_fill, n_fill;
    logic [IW-1:0] r_free, n_free;
    logic r_done, n_done;
    logic [kdll_pkg::STATUS_W-1:0] r_status, n_status;
    logic [kdll_pkg::NAME_W-1:0] r_name_out, n_name_out;
    logic [kdll_pkg::ENTRIES_W-1:0] r_entries, n_entries;

    logic [AW-1:0] rd_addr;
    logic signed [kdll_pkg::KEY_W-1:0] rd_key;
    logic [kdll_pkg::NAME_W-1:0] rd_name;
    logic [IW-1:0] rd_next, rd_prev;
    logic kn_we, nx_we, pv_we;
    logic [AW-1:0] nx_addr, pv_addr;
    logic [IW-1:0] nx_wdata, pv_wdata;

    kdll_store #(
        .NODES(NODES),
        .IW(IW),
        .AW(AW)
    ) u_store (
        .i_clk(i_clk),
        .i_rd_addr(rd_addr),
        .o_rd_key(rd_key),
        .o_rd_name(rd_name),
        .o_rd_next(rd_next),
        .o_rd_prev(rd_prev),
        .i_kn_we(kn_we),
        .i_kn_addr(r_n[AW-1:0]),
        .i_key_wdata(r_key),
        .i_name_wdata(r_name_in),
        .i_nx_we(nx_we),
        .i_nx_addr(nx_addr),
        .i_nx_wdata(nx_wdata),
        .i_pv_we(pv_we),
        .i_pv_addr(pv_addr),
        .i_pv_wdata(pv_wdata)
    );

    assign busy       = (r_state != S_IDLE);
    assign o_done     = r_done;
    assign o_status   = r_status;
    assign o_name_out = r_name_out;
    assign o_entries  = r_entries;

    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_tgt      = r_tgt;
        n_key      = r_key;
        n_name_in  = r_name_in;
        n_hit      = r_hit;
        n_at       = r_at;
        n_steps    = r_steps;
        n_p        = r_p;
        n_pn       = r_pn;
        n_pp       = r_pp;
        n_n        = r_n;
        n_empty    = r_empty;
        n_head     = r_head;
        n_tail     = r_tail;
        n_count    = r_count;
        n_fill     = r_fill;
        n_free     = r_free;
        n_done     = 1'b0;
        n_status   = r_status;
        n_name_out = r_name_out;
        n_entries  = r_entries;
        rd_addr    = r_at[AW-1:0];
        kn_we      = 1'b0;
        nx_we      = 1'b0;
        nx_addr    = r_n[AW-1:0];
        nx_wdata   = NIL;
        pv_we      = 1'b0;
        pv_addr    = r_n[AW-1:0];
        pv_wdata   = NIL;

        unique case (r_state)
            S_IDLE: begin
                rd_addr = r_head[AW-1:0];
                if (start) begin
                    n_cmd     = i_cmd;
                    n_key     = i_key;
                    n_name_in = i_name_in;
                    n_at      = r_head;
                    n_steps   = '0;
                    n_empty   = 1'b0;
                    if (i_cmd == kdll_pkg::CMD_SEARCH || i_cmd == kdll_pkg::CMD_DELETE) begin
                        n_tgt = i_key;
                        if (r_count == '0) begin
                            n_done     = 1'b1;
                            n_status   = kdll_pkg::ST_EMPTY;
                            n_name_out = '0;
                            n_entries  = kdll_pkg::ENTRIES_W'(r_count);
                        end else begin
                            n_state = S_WALK;
                        end
                    end else begin
                        n_tgt = i_ref_key;
                        if (r_count == NIL) begin
                            n_done     = 1'b1;
                            n_status   = kdll_pkg::ST_FULL;
                            n_name_out = '0;
                            n_entries  = kdll_pkg::ENTRIES_W'(r_count);
                        end else if (r_count == '0) begin
                            n_empty = 1'b1;
                            n_state = S_ALLOC;
                        end else begin
                            n_state = S_WALK;
                        end
                    end
                end
            end

            // The read data belongs to r_at; the next node is fetched in the same
            // cycle straight from the returned link, so the walk runs one node a cycle.
            S_WALK: begin
                rd_addr = rd_next[AW-1:0];
                if (rd_key == r_tgt) begin
                    n_p   = r_at;
                    n_pn  = rd_next;
                    n_pp  = rd_prev;
                    n_hit = rd_name;
                    if (r_cmd == kdll_pkg::CMD_SEARCH) begin
                        n_state    = S_IDLE;
                        n_done     = 1'b1;
                        n_status   = kdll_pkg::ST_DONE;
                        n_name_out = rd_name;
                        n_entries  = kdll_pkg::ENTRIES_W'(r_count);
                    end else if (r_cmd == kdll_pkg::CMD_DELETE) begin
                        n_state = S_DEL1;
                    end else begin
                        n_state = S_ALLOC;
                    end
                end else if (r_steps == r_count - IW'(1) || rd_next == NIL) begin
                    n_state    = S_IDLE;
                    n_done     = 1'b1;
                    n_status   = kdll_pkg::ST_NOT_FOUND;
                    n_name_out = '0;
                    n_entries  = kdll_pkg::ENTRIES_W'(r_count);
                end else begin
                    n_at    = rd_next;
                    n_steps = r_steps + IW'(1);
                end
            end

            // Never-used nodes are handed out first; after that, freed nodes come
            // off a free chain threaded through the next memory.
            S_ALLOC: begin
                if (r_fill != NIL) begin
                    n_n     = r_fill;
                    n_fill  = r_fill + IW'(1);
                    n_state = S_LINK1;
                end else begin
                    rd_addr = r_free[AW-1:0];
                    n_state = S_POP;
                end
            end

            S_POP: begin
                n_n     = r_free;
                n_free  = rd_next;
                n_state = S_LINK1;
            end

            S_LINK1: begin
                kn_we   = 1'b1;
                nx_we   = 1'b1;
                pv_we   = 1'b1;
                nx_addr = r_n[AW-1:0];
                pv_addr = r_n[AW-1:0];
                if (r_empty) begin
                    nx_wdata   = NIL;
                    pv_wdata   = NIL;
                    n_head     = r_n;
                    n_tail     = r_n;
                    n_count    = IW'(1);
                    n_state    = S_IDLE;
                    n_done     = 1'b1;
                    n_status   = kdll_pkg::ST_DONE;
                    n_name_out = '0;
                    n_entries  = kdll_pkg::ENTRIES_W'(1);
                end else if (r_cmd == kdll_pkg::CMD_INS_AFTER) begin
                    nx_wdata = r_pn;
                    pv_wdata = r_p;
                    n_state  = S_LINK2;
                end else begin
                    nx_wdata = r_p;
                    pv_wdata = r_pp;
                    n_state  = S_LINK2;
                end
            end

            S_LINK2: begin
                if (r_cmd == kdll_pkg::CMD_INS_AFTER) begin
                    nx_we    = 1'b1;
                    nx_addr  = r_p[AW-1:0];
                    nx_wdata = r_n;
                    if (r_pn != NIL) begin
                        pv_we    = 1'b1;
                        pv_addr  = r_pn[AW-1:0];
                        pv_wdata = r_n;
                    end else begin
                        n_tail = r_n;
                    end
                end else begin
                    pv_we    = 1'b1;
                    pv_addr  = r_p[AW-1:0];
                    pv_wdata = r_n;
                    if (r_pp != NIL) begin
                        nx_we    = 1'b1;
                        nx_addr  = r_pp[AW-1:0];
                        nx_wdata = r_n;
                    end else begin
                        n_head = r_n;
                    end
                end
                n_count    = r_count + IW'(1);
                n_state    = S_IDLE;
                n_done     = 1'b1;
                n_status   = kdll_pkg::ST_DONE;
                n_name_out = '0;
                n_entries  = kdll_pkg::ENTRIES_W'(r_count + IW'(1));
            end

            S_DEL1: begin
                if (r_pp != NIL) begin
                    nx_we    = 1'b1;
                    nx_addr  = r_pp[AW-1:0];
                    nx_wdata = r_pn;
                end else begin
                    n_head = r_pn;
                end
                if (r_pn != NIL) begin
                    pv_we    = 1'b1;
                    pv_addr  = r_pn[AW-1:0];
                    pv_wdata = r_pp;
                end else begin
                    n_tail = r_pp;
                end
                n_state = S_DEL2;
            end

            S_DEL2: begin
                nx_we      = 1'b1;
                nx_addr    = r_p[AW-1:0];
                nx_wdata   = r_free;
                n_free     = r_p;
                n_count    = r_count - IW'(1);
                n_state    = S_IDLE;
                n_done     = 1'b1;
                n_status   = kdll_pkg::ST_DONE;
                n_name_out = r_hit;
                n_entries  = kdll_pkg::ENTRIES_W'(r_count - IW'(1));
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= NIL;
            r_tail  <= NIL;
            r_count <= '0;
            r_fill  <= '0;
            r_free  <= NIL;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            r_fill  <= n_fill;
            r_free  <= n_free;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_tgt      <= n_tgt;
        r_key      <= n_key;
        r_name_in  <= n_name_in;
        r_hit      <= n_hit;
        r_at       <= n_at;
        r_steps    <= n_steps;
        r_p        <= n_p;
        r_pn       <= n_pn;
        r_pp       <= n_pp;
        r_n        <= n_n;
        r_empty    <= n_empty;
        r_status   <= n_status;
        r_name_out <= n_name_out;
        r_entries  <= n_entries;
    end

endmodule

// File: src/kdll_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the keyed doubly linked list unit, bound to the top level.
// Uses kdll_pkg for status codes and widths.
module kdll_checker #(
    parameter int NODES = kdll_pkg::NODES_DEF
) (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 start,
    input logic                                 busy,
    input logic [kdll_pkg::CMD_W-1:0]           i_cmd,
    input logic signed [kdll_pkg::KEY_W-1:0]    i_key,
    input logic signed [kdll_pkg::KEY_W-1:0]    i_ref_key,
    input logic [kdll_pkg::NAME_W-1:0]          i_name_in,
    input logic                                 o_done,
    input logic [kdll_pkg::STATUS_W-1:0]        o_status,
    input logic [kdll_pkg::NAME_W-1:0]          o_name_out,
    input logic [kdll_pkg::ENTRIES_W-1:0]       o_entries
);

    // Every accepted command either makes the unit busy or answers right away.
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy || o_done)
        else $error("accepted command neither went busy nor answered");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_status == kdll_pkg::ST_EMPTY |-> o_entries == '0 && o_name_out == '0)
        else $error("empty-list result carries entries or a name");

    a_full_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_status == kdll_pkg::ST_FULL
            |-> o_entries == kdll_pkg::ENTRIES_W'(NODES) && o_name_out == '0)
        else $error("pool-full result with wrong entry count or a name");

    a_not_found_name: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_status == kdll_pkg::ST_NOT_FOUND |-> o_name_out == '0)
        else $error("not-found result carries a name");

    // A result only follows a command that was in progress or just transferred.
    a_no_spurious_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy) || ($past(start) && !$past(busy)))
        else $error("result without a command");

endmodule

bind keyed_doubly_linked_list_unit kdll_checker #(.NODES(NODES)) u_kdll_checker (.*);
